// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define IAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on any rising edge of clk while rst_n is high.
`define IAFP_NEVER(lbl, cond, msg) \
  `IAFP_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/iafp_pkg.sv =====
// Types and constants shared by the attitude frame parser modules.
package iafp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] fill_t;

  // A frame is twelve bytes long. The checksum covers bytes two to ten.
  localparam int unsigned WIN_LEN  = 12;
  localparam int unsigned SUM_END  = 11;
  localparam fill_t       FILL_LAST = fill_t'(WIN_LEN - 1);

  localparam byte_t HDR0     = 8'hAA;
  localparam byte_t HDR1     = 8'h55;
  localparam byte_t LEN_CODE = 8'h06;

  localparam int unsigned HDR0_OFS = 0;
  localparam int unsigned HDR1_OFS = 1;
  localparam int unsigned LEN_OFS  = 4;
  localparam int unsigned YAW_OFS  = 5;
  localparam int unsigned PIT_OFS  = 7;
  localparam int unsigned ROL_OFS  = 9;

  typedef struct packed {
    logic [15:0]        yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/iafp_front.sv =====
// Front part: byte window, frame check and push of decoded angles.
`include "assert_macros.svh"

module iafp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  iafp_pkg::byte_t  in_rx_byte,
  input  iafp_pkg::q_stat_t q_stat,
  output logic             push,
  output iafp_pkg::frame_t push_frame
);
  import iafp_pkg::*;

  byte_t win_r [WIN_LEN];
  byte_t cand  [WIN_LEN];
  fill_t fill_r;
  fill_t fill_nxt;
  logic  acc;
  logic  hit;
  byte_t sum_a, sum_b, sum_c, sum_d, sum_ab, sum_cd, sum_all;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;

  // The window as it stands once the incoming byte has shifted in.
  always_comb begin
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      cand[k] = win_r[k + 1];
    end
    cand[WIN_LEN - 1] = in_rx_byte;
  end

  // Modulo-256 sum of bytes two to ten as a shallow tree.
  always_comb begin
    sum_a   = byte_t'(cand[2] + cand[3]);
    sum_b   = byte_t'(cand[4] + cand[5]);
    sum_c   = byte_t'(cand[6] + cand[7]);
    sum_d   = byte_t'(cand[8] + cand[9]);
    sum_ab  = byte_t'(sum_a + sum_b);
    sum_cd  = byte_t'(sum_c + sum_d);
    sum_all = byte_t'(sum_ab + sum_cd + cand[10]);
  end

  assign hit = acc && (fill_r == FILL_LAST)
            && (cand[HDR0_OFS] == HDR0) && (cand[HDR1_OFS] == HDR1)
            && (cand[LEN_OFS] == LEN_CODE) && (sum_all == cand[SUM_END]);

  always_comb begin
    fill_nxt = fill_r;
    if (acc) begin
      priority if (hit) begin
        fill_nxt = '0;
      end else if (fill_r == FILL_LAST) begin
        fill_nxt = FILL_LAST;
      end else begin
        fill_nxt = fill_t'(fill_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_r[k] <= cand[k];
      end
    end
  end

  assign push             = hit;
  assign push_frame.yaw   = {cand[YAW_OFS + 1], cand[YAW_OFS]};
  assign push_frame.pitch = {cand[PIT_OFS + 1], cand[PIT_OFS]};
  assign push_frame.roll  = {cand[ROL_OFS + 1], cand[ROL_OFS]};

  `IAFP_NEVER(a_fill_max, fill_r > FILL_LAST, "window fill beyond eleven")
  `IAFP_ASSERT(a_hit_empties, hit |=> fill_r == '0, "window not emptied after a frame")
  `IAFP_ASSERT(a_miss_slides, acc && !hit && (fill_r == FILL_LAST) |=> fill_r == FILL_LAST,
               "window did not slide by one after a miss")

endmodule

// ===== rtl/iafp_queue.sv =====
// Short queue of decoded frames between the front and back parts.
`include "assert_macros.svh"

module iafp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iafp_pkg::frame_t  push_frame,
  input  logic              pop,
  output iafp_pkg::frame_t  head_frame,
  output iafp_pkg::q_stat_t q_stat
);
  import iafp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  frame_t        slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign head_frame   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = CW'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = CW'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_frame;
    end
  end

  `IAFP_NEVER(a_q_count, cnt_r > CNT_FULL, "queue count beyond its depth")
  `IAFP_NEVER(a_q_overrun, push && q_stat.full, "push into a full queue")
  `IAFP_NEVER(a_q_underrun, pop && q_stat.empty, "pop from an empty queue")
  `IAFP_ASSERT(a_q_hold, !push && !pop |=> cnt_r == $past(cnt_r),
               "queue count moved without a push or pop")

endmodule

// ===== rtl/iafp_back.sv =====
// Back part: frame counter and registered result stage.
module iafp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  iafp_pkg::q_stat_t q_stat,
  input  iafp_pkg::frame_t  head_frame,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_yaw_centideg,
  output logic signed [15:0] out_pitch_centideg,
  output logic signed [15:0] out_roll_centideg,
  output logic [31:0]       out_frames_seen
);
  import iafp_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] count_r, count_nxt;
  frame_t      frame_r;

  // The result register reloads when a frame waits and it is empty or its beat is taken.
  assign pop = !q_stat.empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (pop) begin
      valid_nxt = 1'b1;
      count_nxt = count_r + 32'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= head_frame;
    end
  end

  assign out_valid          = valid_r;
  assign out_yaw_centideg   = frame_r.yaw;
  assign out_pitch_centideg = frame_r.pitch;
  assign out_roll_centideg  = frame_r.roll;
  assign out_frames_seen    = count_r;

endmodule

// ===== rtl/imu_attitude_frame_parser_unit.sv =====
// Top level of the attitude frame parser: front part, frame queue and back part.

// This block hunts for twelve-byte attitude frames in a stream of received
// serial bytes, one byte per input beat. A frame starts with the header bytes
// 0xAA 0x55, carries the length code 0x06 at offset four, and ends in a byte
// that equals the modulo-256 sum of bytes two to ten. When the most recent
// twelve bytes since the last frame form such a frame, one result beat is
// produced with yaw (unsigned), pitch and roll (two's complement), each taken
// little-endian in hundredths of a degree, together with a 32-bit count of
// frames passed to the output so far, which wraps. The window then starts
// empty; a miss simply slides it along by one byte. The block takes one byte
// every clock cycle while the queue is not full: the frame check, a small
// adder tree over nine bytes plus a few compares, completes in the cycle in
// which the closing byte is accepted, and the decoded frame is pushed into a
// short queue at that same edge. The back part moves the head of the queue
// into the output register when the queue holds a frame and the register is
// empty or its beat is taken. The input is stalled only while the queue is
// full, which happens only once QUEUE_DEPTH decoded frames have piled up
// behind a result that the output side holds off; QUEUE_DEPTH sets how many
// decoded frames may wait.
`include "assert_macros.svh"

module imu_attitude_frame_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_yaw_centideg,
  output logic signed [15:0] out_pitch_centideg,
  output logic signed [15:0] out_roll_centideg,
  output logic [31:0]        out_frames_seen
);
  import iafp_pkg::*;

  // Queue status travels to both parts as one struct.
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  frame_t  push_frame;
  frame_t  head_frame;

  // Front part: keeps the byte window and decides, beat by beat, whether the
  // window now holds a good frame.
  iafp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  // Decoded frames wait here so that a stalled output does not at once stop
  // the byte stream.
  iafp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .q_stat     (q_stat)
  );

  // Back part: counts frames and holds the result beat until it is taken.
  iafp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .head_frame         (head_frame),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_yaw_centideg   (out_yaw_centideg),
    .out_pitch_centideg (out_pitch_centideg),
    .out_roll_centideg  (out_roll_centideg),
    .out_frames_seen    (out_frames_seen)
  );

  // A frame found on an accepted byte must be waiting or on show next cycle.
  `IAFP_ASSERT(a_frame_kept, push |=> out_valid || !q_stat.empty,
               "found frame was lost")
  // The frame count moves by exactly one with each new result beat.
  `IAFP_ASSERT(a_count_step, pop |=> out_frames_seen == $past(out_frames_seen) + 32'd1,
               "frame count did not advance by one")
  // With no new result loaded, a result on show keeps its count.
  `IAFP_ASSERT(a_count_hold, !pop |=> out_frames_seen == $past(out_frames_seen),
               "frame count changed without a new result")

endmodule
